/* hw/rtl/mof_pkg.sv */
// shared types, register codes and pipeline step functions for the manning edge flux block
// no dependencies; imported by the top level, mof_grad, mof_root and mof_quot
package mof_pkg;

  // pipeline lengths of the stepped units
  localparam int GradSteps = 63;
  localparam int RootSteps = 47;
  localparam int CbrtSteps = 26;
  localparam int QuotSteps = 47;

  // configuration register indexes
  localparam logic [1:0] CfgWaveMode      = 2'd0;
  localparam logic [1:0] CfgDepression    = 2'd1;
  localparam logic [1:0] CfgMinGradient   = 2'd2;

  // saturation limits of the signed q32.16 result
  localparam logic [47:0] FlowMaxPos = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] FlowMaxNeg = 48'h8000_0000_0000;

  typedef struct packed {
    logic        wave_mode;
    logic [30:0] depression_storage;
    logic [29:0] min_gradient;
  } cfg_t;

  typedef struct packed {
    logic [30:0]        slope_magnitude;
    logic [30:0]        nbr_roughness;
    logic [30:0]        own_roughness;
    logic [30:0]        edge_length;
    logic [30:0]        center_distance;
    logic signed [31:0] nbr_elevation;
    logic [30:0]        nbr_depth;
    logic signed [31:0] own_elevation;
    logic [30:0]        own_depth;
  } mof_item_t;

  // per-item data that rides along the gradient divider
  typedef struct packed {
    logic        neg;
    logic        pos;
    logic [30:0] h;
    logic [30:0] slope;
    logic [30:0] edge_len;
    logic [31:0] rsum;
  } mof_side_t;

  typedef struct packed {
    mof_side_t   side;
    logic [30:0] span;
    logic [30:0] rem;
    logic [62:0] nq;
  } mof_grad_t;

  typedef struct packed {
    logic        neg;
    logic [62:0] g;
    logic [45:0] a;
    logic [31:0] rsum;
    logic [93:0] xs;
    logic [46:0] ys;
    logic [49:0] rs;
    logic [77:0] xc;
    logic [25:0] yc;
    logic [51:0] yc2;
    logic [59:0] rc;
  } mof_root_t;

  typedef struct packed {
    logic        neg;
    logic [62:0] g;
    logic [48:0] pa_lo;
    logic [48:0] pa_hi;
    logic [55:0] ds_lo;
    logic [54:0] ds_hi;
  } mof_p1_t;

  typedef struct packed {
    logic        neg;
    logic [62:0] g;
    logic [55:0] b;
    logic [78:0] den;
  } mof_p2_t;

  typedef struct packed {
    logic        neg;
    logic [78:0] den;
    logic [59:0] pp0;
    logic [58:0] pp1;
    logic [59:0] pp2;
    logic [58:0] pp3;
  } mof_p3_t;

  // numerator and denominator handed to the final divider
  typedef struct packed {
    logic         neg;
    logic [78:0]  den;
    logic [118:0] num;
  } mof_frac_t;

  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [78:0] den;
    logic [78:0] rem;
    logic [46:0] nq;
  } mof_quot_t;

  // one restoring step of the gradient divider
  function automatic mof_grad_t grad_step(mof_grad_t cur);
    mof_grad_t   nxt;
    logic [31:0] r2;
    logic        ge;
    nxt = cur;
    r2  = {cur.rem, cur.nq[62]};
    ge  = (r2 >= {1'b0, cur.span});
    nxt.rem = ge ? 31'(r2 - {1'b0, cur.span}) : r2[30:0];
    nxt.nq  = {cur.nq[61:0], ge};
    return nxt;
  endfunction

  // one digit of the square root and, when enabled, one digit of the cube root
  function automatic mof_root_t root_step(mof_root_t cur, logic do_cbrt);
    mof_root_t   nxt;
    logic [51:0] r2s;
    logic [51:0] cs;
    logic        ges;
    logic [62:0] r2c;
    logic [62:0] cc;
    logic        gec;
    nxt = cur;
    r2s = {cur.rs, cur.xs[93:92]};
    cs  = {3'b0, cur.ys, 2'b01};
    ges = (r2s >= cs);
    nxt.rs = ges ? 50'(r2s - cs) : r2s[49:0];
    nxt.ys = {cur.ys[45:0], ges};
    nxt.xs = {cur.xs[91:0], 2'b00};
    // cube root: try 2y+1, cost 12y^2 + 6y + 1
    r2c = {cur.rc, cur.xc[77:75]};
    cc  = 63'({cur.yc2, 3'b000}) + 63'({cur.yc2, 2'b00}) + 63'({cur.yc, 2'b00})
        + 63'({cur.yc, 1'b0}) + 63'd1;
    gec = (r2c >= cc);
    if (do_cbrt) begin
      nxt.rc  = gec ? 60'(r2c - cc) : r2c[59:0];
      nxt.yc2 = gec ? 52'({cur.yc2, 2'b00}) + 52'({cur.yc, 2'b00}) + 52'd1
                    : 52'({cur.yc2, 2'b00});
      nxt.yc  = {cur.yc[24:0], gec};
      nxt.xc  = {cur.xc[74:0], 3'b000};
    end
    return nxt;
  endfunction

  // one restoring step of the flux divider
  function automatic mof_quot_t quot_step(mof_quot_t cur);
    mof_quot_t   nxt;
    logic [79:0] r2;
    logic        ge;
    nxt = cur;
    r2  = {cur.rem, cur.nq[46]};
    ge  = (r2 >= {1'b0, cur.den});
    nxt.rem = ge ? 79'(r2 - {1'b0, cur.den}) : r2[78:0];
    nxt.nq  = {cur.nq[45:0], ge};
    return nxt;
  endfunction

endpackage

/* hw/rtl/manning_overland_edge_flux.sv */
// Manning overland flux across one mesh edge: one request accepted per clock while the
// two-entry output buffer is not full. The pipeline depth is set by the
// one-bit-per-stage dividers (63 gradient stages, 47 flux stages) and the 47-stage square
// root; all stages hold together only when the two-entry output buffer is full.
// Registers are read live, so write them only while the block is idle.
// depends on mof_pkg, mof_grad, mof_root, mof_quot
module manning_overland_edge_flux import mof_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,   // own_depth, own_elevation, nbr_depth, nbr_elevation,
                                  // center_distance, edge_length, own_roughness,
                                  // nbr_roughness, slope_magnitude, zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,   // flow_rate
  output logic         m_tuser,   // saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  cfg_t        cfg;
  mof_item_t   item;
  logic        en;
  logic        g_valid;
  mof_side_t   g_side;
  logic [62:0] g_val;
  logic        r_valid;
  mof_frac_t   r_frac;
  logic        q_valid;
  logic [47:0] q_flow;
  logic        q_sat;

  logic [48:0] obuf [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign item      = s_tdata[280:0];
  assign en        = (count != 2'd2);
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_mode          <= 1'b1;
      cfg.depression_storage <= 31'd66;
      cfg.min_gradient       <= 30'd54;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgWaveMode:    cfg.wave_mode          <= cfg_data[0];
        CfgDepression:  cfg.depression_storage <= cfg_data[30:0];
        CfgMinGradient: cfg.min_gradient       <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  mof_grad u_grad (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .item      (item),
    .out_valid (g_valid),
    .side      (g_side),
    .g         (g_val)
  );

  mof_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (g_valid),
    .side      (g_side),
    .g         (g_val),
    .out_valid (r_valid),
    .frac      (r_frac)
  );

  mof_quot u_quot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .frac      (r_frac),
    .out_valid (q_valid),
    .flow_rate (q_flow),
    .saturated (q_sat)
  );

  // two-entry output buffer
  assign push = en && q_valid;
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= {q_sat, q_flow};
    end
  end

  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = obuf[rd_ptr][47:0];
  assign m_tuser  = obuf[rd_ptr][48];

endmodule

/* hw/rtl/mof_grad.sv */
// head difference, flow depth and pipelined gradient divider (|diff| * 2^30 / distance)
// depends on mof_pkg
module mof_grad import mof_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  cfg_t      cfg,
  input  logic      in_valid,
  input  mof_item_t item,
  output logic      out_valid,
  output mof_side_t side,
  output logic [62:0] g
);

  logic [GradSteps:0] vld;
  mof_grad_t          stg [GradSteps+1];

  logic signed [34:0] head_own;
  logic signed [34:0] head_nbr;
  logic signed [34:0] diff;
  logic [32:0]        mag;
  logic [30:0]        up;
  logic [31:0]        rsum;
  mof_grad_t          init;

  // heads, upstream depth and divider seed
  always_comb begin
    head_own = {{3{item.own_elevation[31]}}, item.own_elevation}
             + (cfg.wave_mode ? 35'd0 : {4'b0, item.own_depth});
    head_nbr = {{3{item.nbr_elevation[31]}}, item.nbr_elevation}
             + (cfg.wave_mode ? 35'd0 : {4'b0, item.nbr_depth});
    diff = head_own - head_nbr;
    init.side.neg = diff[34];
    init.side.pos = !diff[34] && (diff != 35'sd0);
    mag  = diff[34] ? 33'(-diff) : diff[32:0];
    up   = init.side.pos ? item.own_depth : item.nbr_depth;
    init.side.h = (up > cfg.depression_storage) ? up - cfg.depression_storage : 31'd0;
    init.side.slope    = item.slope_magnitude;
    init.side.edge_len = item.edge_length;
    rsum = {1'b0, item.own_roughness} + {1'b0, item.nbr_roughness};
    init.side.rsum = (rsum == 32'd0) ? 32'd1 : rsum;
    init.span = (item.center_distance == 31'd0) ? 31'd1 : item.center_distance;
    init.rem  = '0;
    init.nq   = {mag, 30'b0};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[GradSteps-1:0], in_valid};
    end
  end

  // divider stages
  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= init;
      for (int i = 0; i < GradSteps; i++) begin
        stg[i+1] <= grad_step(stg[i]);
      end
    end
  end

  assign out_valid = vld[GradSteps];
  assign side      = stg[GradSteps].side;
  assign g         = stg[GradSteps].nq;

endmodule

/* hw/rtl/mof_root.sv */
// friction slope select, pipelined square and cube roots, and the split product stages
// depends on mof_pkg
module mof_root import mof_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  cfg_t        cfg,
  input  logic        in_valid,
  input  mof_side_t   side,
  input  logic [62:0] g,
  output logic        out_valid,
  output mof_frac_t   frac
);

  logic [RootSteps+4:0] vld;
  mof_root_t            stg [RootSteps+1];
  mof_p1_t              p1;
  mof_p2_t              p2;
  mof_p3_t              p3;
  mof_frac_t            p4;

  logic [62:0] sf;
  logic [61:0] hh;
  logic [61:0] ha;
  mof_root_t   init;
  mof_root_t   last;
  logic [71:0] b_full;

  // slope select and root seeds
  always_comb begin
    if (cfg.wave_mode) begin
      sf = side.pos ? g : {33'b0, cfg.min_gradient};
    end else begin
      sf = (side.slope > {1'b0, cfg.min_gradient}) ? {32'b0, side.slope}
                                                   : {33'b0, cfg.min_gradient};
    end
    if (sf == 63'd0) begin
      sf = 63'd1;
    end
    hh = side.h * side.h;
    ha = side.h * side.edge_len;
    init.neg  = side.neg;
    init.g    = g;
    init.a    = ha[61:16];
    init.rsum = side.rsum;
    init.xs   = {1'b0, sf, 30'b0};
    init.ys   = '0;
    init.rs   = '0;
    init.xc   = {hh, 16'b0};
    init.yc   = '0;
    init.yc2  = '0;
    init.rc   = '0;
  end

  assign last   = stg[RootSteps];
  assign b_full = {p1.pa_hi, 23'b0} + {23'b0, p1.pa_lo};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RootSteps+3:0], in_valid};
    end
  end

  // root stages
  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= init;
      for (int i = 0; i < RootSteps; i++) begin
        stg[i+1] <= root_step(stg[i], (i < CbrtSteps));
      end
    end
  end

  // depth*edge*depth^(2/3) and sqrt(slope)*roughness, then the numerator
  always_ff @(posedge clk) begin
    if (en) begin
      p1.neg   <= last.neg;
      p1.g     <= last.g;
      p1.pa_lo <= last.a[22:0] * last.yc;
      p1.pa_hi <= last.a[45:23] * last.yc;
      p1.ds_lo <= last.ys[23:0] * last.rsum;
      p1.ds_hi <= last.ys[46:24] * last.rsum;

      p2.neg <= p1.neg;
      p2.g   <= p1.g;
      p2.b   <= b_full[71:16];
      p2.den <= {p1.ds_hi, 24'b0} + {23'b0, p1.ds_lo};

      p3.neg <= p2.neg;
      p3.den <= p2.den;
      p3.pp0 <= p2.b[27:0] * p2.g[31:0];
      p3.pp1 <= p2.b[27:0] * p2.g[62:32];
      p3.pp2 <= p2.b[55:28] * p2.g[31:0];
      p3.pp3 <= p2.b[55:28] * p2.g[62:32];

      p4.neg <= p3.neg;
      p4.den <= p3.den;
      p4.num <= {p3.pp3, 60'b0} + {31'b0, p3.pp2, 28'b0} + {28'b0, p3.pp1, 32'b0}
              + {59'b0, p3.pp0};
    end
  end

  assign out_valid = vld[RootSteps+4];
  assign frac      = p4;

endmodule

/* hw/rtl/mof_quot.sv */
// overflow check, pipelined flux divider (num * 2^17 / den) and signed saturation
// depends on mof_pkg
module mof_quot import mof_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  mof_frac_t   frac,
  output logic        out_valid,
  output logic [47:0] flow_rate,
  output logic        saturated
);

  logic [QuotSteps+1:0] vld;
  mof_quot_t            stg [QuotSteps+1];
  mof_quot_t            init;
  mof_quot_t            last;
  logic [47:0]          mag;

  // quotient of 2^47 or more saturates
  always_comb begin
    init.neg = frac.neg;
    init.sat = (frac.num >= {10'b0, frac.den, 30'b0});
    init.den = frac.den;
    init.rem = frac.num[108:30];
    init.nq  = {frac.num[29:0], 17'b0};
  end

  assign last = stg[QuotSteps];
  assign mag  = {1'b0, last.nq};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QuotSteps:0], in_valid};
    end
  end

  // divider stages and result register
  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= init;
      for (int i = 0; i < QuotSteps; i++) begin
        stg[i+1] <= quot_step(stg[i]);
      end
      saturated <= last.sat;
      if (last.sat) begin
        flow_rate <= last.neg ? FlowMaxNeg : FlowMaxPos;
      end else begin
        flow_rate <= last.neg ? 48'(-mag) : mag;
      end
    end
  end

  assign out_valid = vld[QuotSteps+1];

endmodule

/* hw/rtl/mof_check.sv */
// port-level assertions for the manning edge flux block, bound to the top level
// depends on manning_overland_edge_flux
module mof_check (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [47:0]  m_tdata,
  input logic         m_tuser
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a saturated result sits at one of the two limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == 48'h7FFF_FFFF_FFFF) ||
                            (m_tdata == 48'h8000_0000_0000))
    else $error("saturated flag without a limit value");

  // reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

endmodule

bind manning_overland_edge_flux mof_check u_check (.*);
